// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the string decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, checked outside reset.
`define JSU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define JSU_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and codes shared by the JSON string decoder modules.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Decoder phase within one string literal.
    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } phase_t;

    // Kind of one result item.
    typedef enum logic [1:0] {
        RK_BYTE = 2'd0,
        RK_DONE = 2'd1,
        RK_ERR  = 2'd2
    } res_kind_t;

    // Error codes reported with an error result.
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_QUOTE     = 3'd1,
        ERR_UNTERM_ESC = 3'd2,
        ERR_BAD_UNI   = 3'd3,
        ERR_BAD_ESC   = 3'd4,
        ERR_UNTERM_STR = 3'd5
    } err_code_t;

    // Input kind codes.
    localparam logic IN_BYTE = 1'b0;
    localparam logic IN_END  = 1'b1;

    // Source characters with a special meaning.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;

    // Maximum number of result items caused by one input item.
    localparam int MAX_RES = 3;

    // All result items caused by one input item.
    typedef struct packed {
        logic [1:0]              count;
        res_kind_t               kind;
        err_code_t               err;
        logic [MAX_RES-1:0][7:0] bytes;
    } jsu_res_t;

endpackage

// File: rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Phase tracking and per-item decode of escapes and unicode digits.
// ----------------------------------------------------------------------------
module jsu_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic               kind,
    input  logic [7:0]         data_byte,
    output jsu_pkg::jsu_res_t  res
);

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      hex_cnt_reg, hex_cnt_next;
    // Only the first three digits are held; the fourth comes from the input.
    logic [11:0]     accum_reg, accum_next;

    logic            is_end;
    logic            hex_ok;
    logic [3:0]      hex_val;
    logic [15:0]     code_point;

    assign is_end = (kind == jsu_pkg::IN_END);

    // Hex digit value of the source byte, either case.
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (data_byte >= 8'h30 && data_byte <= 8'h39)
        begin
            hex_val = 4'(data_byte - 8'h30);
        end
        else if (data_byte >= 8'h61 && data_byte <= 8'h66)
        begin
            hex_val = 4'(data_byte - 8'h57);
        end
        else if (data_byte >= 8'h41 && data_byte <= 8'h46)
        begin
            hex_val = 4'(data_byte - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign code_point = {accum_reg, hex_val};

    // Next phase and digit gathering.
    always_comb
    begin
        phase_next   = phase_reg;
        hex_cnt_next = hex_cnt_reg;
        accum_next   = accum_reg;
        if (take)
        begin
            unique case (phase_reg)
                jsu_pkg::PH_WAIT:
                begin
                    if (!is_end && data_byte == jsu_pkg::CH_QUOTE)
                    begin
                        phase_next = jsu_pkg::PH_STR;
                    end
                end
                jsu_pkg::PH_STR:
                begin
                    if (is_end || data_byte == jsu_pkg::CH_QUOTE)
                    begin
                        phase_next = jsu_pkg::PH_WAIT;
                    end
                    else if (data_byte == jsu_pkg::CH_BSLASH)
                    begin
                        phase_next = jsu_pkg::PH_ESC;
                    end
                end
                jsu_pkg::PH_ESC:
                begin
                    hex_cnt_next = 2'd0;
                    accum_next   = 12'd0;
                    if (is_end)
                    begin
                        phase_next = jsu_pkg::PH_WAIT;
                    end
                    else
                    begin
                        unique case (data_byte)
                            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                            jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                            jsu_pkg::CH_R, jsu_pkg::CH_T:
                                phase_next = jsu_pkg::PH_STR;
                            jsu_pkg::CH_U:
                                phase_next = jsu_pkg::PH_HEX;
                            default:
                                phase_next = jsu_pkg::PH_WAIT;
                        endcase
                    end
                end
                jsu_pkg::PH_HEX:
                begin
                    if (is_end || !hex_ok)
                    begin
                        phase_next   = jsu_pkg::PH_WAIT;
                        hex_cnt_next = 2'd0;
                        accum_next   = 12'd0;
                    end
                    else if (hex_cnt_reg == 2'd3)
                    begin
                        phase_next   = jsu_pkg::PH_STR;
                        hex_cnt_next = 2'd0;
                        accum_next   = 12'd0;
                    end
                    else
                    begin
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                        accum_next   = {accum_reg[7:0], hex_val};
                    end
                end
                default:
                begin
                    phase_next = jsu_pkg::PH_WAIT;
                end
            endcase
        end
    end

    // Result items for the item at the input.
    always_comb
    begin
        res       = '0;
        res.kind  = jsu_pkg::RK_BYTE;
        res.err   = jsu_pkg::ERR_NONE;
        unique case (phase_reg)
            jsu_pkg::PH_WAIT:
            begin
                if (is_end || data_byte != jsu_pkg::CH_QUOTE)
                begin
                    res.count = 2'd1;
                    res.kind  = jsu_pkg::RK_ERR;
                    res.err   = jsu_pkg::ERR_QUOTE;
                end
            end
            jsu_pkg::PH_STR:
            begin
                if (is_end)
                begin
                    res.count = 2'd1;
                    res.kind  = jsu_pkg::RK_ERR;
                    res.err   = jsu_pkg::ERR_UNTERM_STR;
                end
                else if (data_byte == jsu_pkg::CH_QUOTE)
                begin
                    res.count = 2'd1;
                    res.kind  = jsu_pkg::RK_DONE;
                end
                else if (data_byte != jsu_pkg::CH_BSLASH)
                begin
                    res.count    = 2'd1;
                    res.bytes[0] = data_byte;
                end
            end
            jsu_pkg::PH_ESC:
            begin
                if (is_end)
                begin
                    res.count = 2'd1;
                    res.kind  = jsu_pkg::RK_ERR;
                    res.err   = jsu_pkg::ERR_UNTERM_ESC;
                end
                else
                begin
                    res.count = 2'd1;
                    unique case (data_byte)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                            res.bytes[0] = data_byte;
                        jsu_pkg::CH_B: res.bytes[0] = 8'h08;
                        jsu_pkg::CH_F: res.bytes[0] = 8'h0C;
                        jsu_pkg::CH_N: res.bytes[0] = 8'h0A;
                        jsu_pkg::CH_R: res.bytes[0] = 8'h0D;
                        jsu_pkg::CH_T: res.bytes[0] = 8'h09;
                        jsu_pkg::CH_U: res.count    = 2'd0;
                        default:
                        begin
                            res.kind = jsu_pkg::RK_ERR;
                            res.err  = jsu_pkg::ERR_BAD_ESC;
                        end
                    endcase
                end
            end
            jsu_pkg::PH_HEX:
            begin
                if (is_end || !hex_ok)
                begin
                    res.count = 2'd1;
                    res.kind  = jsu_pkg::RK_ERR;
                    res.err   = jsu_pkg::ERR_BAD_UNI;
                end
                else if (hex_cnt_reg == 2'd3)
                begin
                    // Encode the gathered code point as UTF-8.
                    if (code_point <= 16'h007F)
                    begin
                        res.count    = 2'd1;
                        res.bytes[0] = code_point[7:0];
                    end
                    else if (code_point <= 16'h07FF)
                    begin
                        res.count    = 2'd2;
                        res.bytes[0] = {3'b110, code_point[10:6]};
                        res.bytes[1] = {2'b10, code_point[5:0]};
                    end
                    else
                    begin
                        res.count    = 2'd3;
                        res.bytes[0] = {4'b1110, code_point[15:12]};
                        res.bytes[1] = {2'b10, code_point[11:6]};
                        res.bytes[2] = {2'b10, code_point[5:0]};
                    end
                end
            end
            default:
            begin
                res.count = 2'd0;
            end
        endcase
    end

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= jsu_pkg::PH_WAIT;
            hex_cnt_reg <= 2'd0;
            accum_reg   <= 12'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hex_cnt_reg <= hex_cnt_next;
            accum_reg   <= accum_next;
        end
    end

endmodule

// File: rtl/jsu_out_buf.sv
// ----------------------------------------------------------------------------
// jsu_out_buf
// Result register that holds up to three result items of one input item and
// hands them out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module jsu_out_buf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  jsu_pkg::jsu_res_t  res,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         result_kind,
    output logic [7:0]         decoded_byte,
    output logic [2:0]         error_code,
    output logic               last
);

    logic [1:0]          cnt_reg, cnt_next;
    jsu_pkg::res_kind_t  kind_reg;
    jsu_pkg::err_code_t  err_reg;
    logic [7:0]          byte_reg [jsu_pkg::MAX_RES];
    logic                pop;

    assign out_valid    = (cnt_reg != 2'd0);
    assign pop          = out_valid && out_ready;
    assign last         = (cnt_reg == 2'd1);
    assign space        = (cnt_reg == 2'd0) || (out_ready && last);
    assign result_kind  = kind_reg;
    assign error_code   = err_reg;
    assign decoded_byte = byte_reg[0];

    // Number of result items still waiting.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = res.count;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload: load a new group, or shift the next byte to the head.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= res.kind;
            err_reg  <= res.err;
            for (int i = 0; i < jsu_pkg::MAX_RES; i++)
            begin
                byte_reg[i] <= res.bytes[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < jsu_pkg::MAX_RES - 1; i++)
            begin
                byte_reg[i] <= byte_reg[i+1];
            end
        end
    end

endmodule

// File: rtl/json_string_unescaper_core.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_core
// Streaming decoder for one quoted JSON string literal to UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one item per source byte, or
// an end-of-source marker when kind is 1. The output channel
// (out_valid/out_ready) carries result items: decoded bytes, a done marker on
// the closing quote, or an error with its code. The last result caused by an
// input item has last set; an item may cause zero to three results.
// Results of an item appear the cycle after it is accepted. One item is taken
// every cycle while each item causes at most one result and the receiver is
// ready; an item that completes a \u escape with more than one UTF-8 byte holds
// the input while the single result register drains its bytes, one byte per
// cycle when the receiver is ready. A new item is taken while the last
// result of the previous one is being handed over.
// Reset clears the phase to waiting for the opening quote and empties the
// result register. When the receiver stalls, results hold and the input
// stops accepting once the last pending result cannot leave.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module json_string_unescaper_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] decoded_byte,
    output logic [2:0] error_code,
    output logic       last
);

    jsu_pkg::jsu_res_t res;
    logic              take;
    logic              space;

    assign in_ready = space;
    assign take     = in_valid && space;

    // Phase tracking and decode of the accepted item.
    jsu_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .kind      (kind),
        .data_byte (data_byte),
        .res       (res)
    );

    // Result register and serializer.
    jsu_out_buf u_out_buf
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (take && (res.count != 2'd0)),
        .res          (res),
        .space        (space),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .decoded_byte (decoded_byte),
        .error_code   (error_code),
        .last         (last)
    );

    // Input is open beside a pending result only while its last one leaves.
    `JSU_ASSERT_IMPLY(a_ready_on_last, out_valid && in_ready, last && out_ready,
        "input ready while earlier results still pending")

    // Done and error results always stand alone.
    `JSU_ASSERT_IMPLY(a_marker_last, out_valid && (result_kind != jsu_pkg::RK_BYTE), last,
        "done or error result not marked last")

    // An error code comes exactly with an error result.
    `JSU_ASSERT_IMPLY(a_err_code, out_valid,
        (result_kind == jsu_pkg::RK_ERR) == (error_code != jsu_pkg::ERR_NONE),
        "error code does not match result kind")

endmodule
